### src/dri_pkg.sv
// Shared constants and helper functions of the dead reckoning integrator.
`default_nettype none
package dri_pkg;

  // Configuration port layout and register indexes.
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_RATE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_THRESHOLD = 8'd1;
  localparam logic [30:0] STOP_THRESHOLD_RESET = 31'd655;

  // Angle constants in Q8.24 and the rotator gain in Q2.30.
  localparam int ANG_W = 34;
  localparam logic signed [ANG_W-1:0] TWO_PI = 34'sd105414357;
  localparam logic signed [ANG_W-1:0] PI_VAL = 34'sd52707179;
  localparam logic signed [ANG_W-1:0] HALF_PI = 34'sd26353589;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Operand width of the serial multiplier and of its product.
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;

  // Arctangent table in Q2.30, one entry per rotation step.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] v;
    begin
      case (idx)
        5'd0: v = 30'd843314857;
        5'd1: v = 30'd497837829;
        5'd2: v = 30'd263043837;
        5'd3: v = 30'd133525159;
        5'd4: v = 30'd67021687;
        5'd5: v = 30'd33543516;
        5'd6: v = 30'd16775851;
        5'd7: v = 30'd8388437;
        5'd8: v = 30'd4194283;
        5'd9: v = 30'd2097149;
        5'd10: v = 30'd1048576;
        5'd11: v = 30'd524288;
        5'd12: v = 30'd262144;
        5'd13: v = 30'd131072;
        5'd14: v = 30'd65536;
        5'd15: v = 30'd32768;
        5'd16: v = 30'd16384;
        5'd17: v = 30'd8192;
        5'd18: v = 30'd4096;
        5'd19: v = 30'd2048;
        5'd20: v = 30'd1024;
        5'd21: v = 30'd512;
        5'd22: v = 30'd256;
        5'd23: v = 30'd128;
        5'd24: v = 30'd64;
        5'd25: v = 30'd32;
        5'd26: v = 30'd16;
        5'd27: v = 30'd8;
        5'd28: v = 30'd4;
        5'd29: v = 30'd2;
        5'd30: v = 30'd1;
        default: v = 30'd0;
      endcase
      return v;
    end
  endfunction

  // Multiple of two pi subtracted in one step of the angle reduction.
  function automatic logic signed [ANG_W-1:0] reduce_step(input logic [2:0] k);
    logic signed [ANG_W-1:0] v;
    begin
      v = TWO_PI <<< k;
      return v;
    end
  endfunction

  // Saturate a signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    begin
      if (v > 40'sd2147483647) begin
        r = 32'sh7fffffff;
      end else if (v < -40'sd2147483648) begin
        r = 32'sh80000000;
      end else begin
        r = v[31:0];
      end
      return r;
    end
  endfunction

  // Saturating 64-bit signed add.
  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [63:0] r;
    begin
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
        r = s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      end else begin
        r = s[63:0];
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### src/dri_if.sv
// Channel interfaces of the dead reckoning integrator: samples, results, configuration.
`default_nettype none

interface dri_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] raw_yaw_rate;
  logic signed [31:0] speed;
  logic signed [31:0] heading;
  logic signed [31:0] moving_offset;
  logic signed [31:0] stop_offset;
  logic moving_offset_valid;
  logic speed_valid;
  logic heading_valid;
  logic [31:0] sample_time;

  modport source (output valid, raw_yaw_rate, speed, heading, moving_offset,
                  stop_offset, moving_offset_valid, speed_valid, heading_valid,
                  sample_time, input ready);
  modport sink (input valid, raw_yaw_rate, speed, heading, moving_offset,
                stop_offset, moving_offset_valid, speed_valid, heading_valid,
                sample_time, output ready);
endinterface

interface dri_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] yaw_rate;
  logic signed [31:0] vel_east;
  logic signed [31:0] vel_north;
  logic signed [63:0] pos_east;
  logic signed [63:0] pos_north;
  logic signed [31:0] heading_out;

  modport source (output valid, yaw_rate, vel_east, vel_north, pos_east, pos_north,
                  heading_out, input ready);
  modport sink (input valid, yaw_rate, vel_east, vel_north, pos_east, pos_north,
                heading_out, output ready);
endinterface

interface dri_cfg_if;
  logic valid;
  logic ready;
  logic [7:0] index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/dead_reckoning_integrator_unit.sv
// Top level of the dead reckoning integrator: yaw correction, velocity and position.
//
//   channel     role   handshake      payload
//   sample_in   sink   valid/ready    IMU sample, speed, heading, offsets, flags, time
//   result_out  source valid/ready    yaw rate, velocities, positions, heading
//   cfg_wr      sink   valid/ready    register index and write data, ready out of reset
//
// A result is loaded after its sample passes through a yaw step, six reduction steps, a
// fold step, the rotations, and two passes of bit-serial multipliers (velocity, then
// position) with their start states. The input opens again in the cycle after the result
// is loaded, so the block works on one sample at a time; a finished result waits in the
// output register meanwhile. Reset is synchronous.
// A stalled output holds the engine in its final state until the result is taken.
`default_nettype none
module dead_reckoning_integrator_unit #(
  parameter int CORDIC_STEPS = 24
) (
  input wire logic clk,
  input wire logic rst,
  dri_in_if.sink sample_in,
  dri_out_if.source result_out,
  dri_cfg_if.sink cfg_wr
);
  import dri_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_ARMED, PH_RUN} phase_t;
  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_TRIG, ST_VSTART, ST_VWAIT, ST_PSTART, ST_PWAIT, ST_DONE
  } state_t;

  state_t state;
  phase_t start_phase;
  phase_t phase_next;
  logic reverse_rate;
  logic [30:0] stop_speed_threshold;
  logic seen_sample;
  logic [31:0] last_time;
  logic signed [31:0] east_velocity_held;
  logic signed [31:0] north_velocity_held;
  logic signed [63:0] east_position;
  logic signed [63:0] north_position;

  // Latched sample.
  logic signed [31:0] raw_q;
  logic signed [31:0] speed_q;
  logic signed [31:0] heading_q;
  logic signed [31:0] mov_off_q;
  logic signed [31:0] stop_off_q;
  logic mov_valid_q;
  logic run_q;
  logic pos_en_q;
  logic [31:0] dt_q;
  logic signed [31:0] yaw_q;

  logic accept;
  logic out_free;
  logic moving;
  logic signed [33:0] rate;
  logic signed [33:0] rate_sum;

  logic trig_done;
  logic signed [ANG_W-1:0] sin_q;
  logic signed [ANG_W-1:0] cos_q;
  logic mul_start;
  logic signed [MUL_W-1:0] mul_a_e;
  logic signed [MUL_W-1:0] mul_a_n;
  logic signed [MUL_W-1:0] mul_b_e;
  logic signed [MUL_W-1:0] mul_b_n;
  logic mul_e_done;
  logic mul_n_done;
  logic signed [PROD_W-1:0] prod_e;
  logic signed [PROD_W-1:0] prod_n;
  logic signed [39:0] vel_e_wide;
  logic signed [39:0] vel_n_wide;

  assign accept = sample_in.valid && sample_in.ready;
  assign sample_in.ready = (state == ST_IDLE) && !rst;
  assign cfg_wr.ready = !rst;
  assign out_free = !result_out.valid || result_out.ready;

  // Start sequence: armed once both estimators are valid, running one sample later.
  always_comb begin
    phase_next = start_phase;
    unique case (start_phase)
      PH_IDLE: begin
        if (sample_in.speed_valid && sample_in.heading_valid) begin
          phase_next = PH_ARMED;
        end
      end
      PH_ARMED: phase_next = PH_RUN;
      default: phase_next = start_phase;
    endcase
  end

  // Yaw rate: optional sign flip, then moving or standstill offset.
  always_comb begin
    moving = ($signed({speed_q[31], speed_q}) > $signed({2'b00, stop_speed_threshold}))
             && mov_valid_q;
    rate = reverse_rate ? -34'(raw_q) : 34'(raw_q);
    rate_sum = rate + (moving ? 34'(mov_off_q) : 34'(stop_off_q));
  end

  // Velocity rounding: (speed * trig + 2^29) >> 30.
  always_comb begin
    vel_e_wide = 40'((prod_e + PROD_W'(1 << 29)) >>> 30);
    vel_n_wide = 40'((prod_n + PROD_W'(1 << 29)) >>> 30);
  end

  // Multiplier operands: speed by trig first, then held velocity by time delta.
  assign mul_start = (state == ST_VSTART) || (state == ST_PSTART);
  always_comb begin
    if (state == ST_VSTART) begin
      mul_a_e = MUL_W'(speed_q);
      mul_a_n = MUL_W'(speed_q);
      mul_b_e = sin_q;
      mul_b_n = cos_q;
    end else begin
      mul_a_e = MUL_W'(east_velocity_held);
      mul_a_n = MUL_W'(north_velocity_held);
      mul_b_e = $signed({2'b00, dt_q});
      mul_b_n = $signed({2'b00, dt_q});
    end
  end

  dri_sincos #(.STEPS(CORDIC_STEPS)) u_sincos (
    .clk(clk),
    .rst(rst),
    .start(state == ST_PREP),
    .heading(heading_q),
    .done(trig_done),
    .sin_q(sin_q),
    .cos_q(cos_q)
  );

  dri_serial_mul u_mul_east (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(mul_a_e),
    .b(mul_b_e),
    .done(mul_e_done),
    .product(prod_e)
  );

  dri_serial_mul u_mul_north (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(mul_a_n),
    .b(mul_b_n),
    .done(mul_n_done),
    .product(prod_n)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      reverse_rate <= 1'b0;
      stop_speed_threshold <= STOP_THRESHOLD_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      if (cfg_wr.index == CFG_REVERSE_RATE) begin
        reverse_rate <= cfg_wr.data[0];
      end else if (cfg_wr.index == CFG_STOP_THRESHOLD) begin
        stop_speed_threshold <= cfg_wr.data[30:0];
      end
    end
  end

  // Sequencer, integration state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start_phase <= PH_IDLE;
      seen_sample <= 1'b0;
      last_time <= '0;
      east_velocity_held <= '0;
      north_velocity_held <= '0;
      east_position <= '0;
      north_position <= '0;
      result_out.valid <= 1'b0;
    end else begin
      // The final state reloads the output register itself when it is taken.
      if (result_out.valid && result_out.ready && state != ST_DONE) begin
        result_out.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            raw_q <= sample_in.raw_yaw_rate;
            speed_q <= sample_in.speed;
            heading_q <= sample_in.heading;
            mov_off_q <= sample_in.moving_offset;
            stop_off_q <= sample_in.stop_offset;
            mov_valid_q <= sample_in.moving_offset_valid;
            start_phase <= phase_next;
            run_q <= (phase_next == PH_RUN);
            pos_en_q <= (phase_next == PH_RUN) && (sample_in.speed > 32'sd0) && seen_sample;
            dt_q <= sample_in.sample_time - last_time;
            last_time <= sample_in.sample_time;
            seen_sample <= 1'b1;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          yaw_q <= sat32(40'(rate_sum));
          state <= ST_TRIG;
        end
        ST_TRIG: begin
          if (trig_done) begin
            state <= ST_VSTART;
          end
        end
        ST_VSTART: state <= ST_VWAIT;
        ST_VWAIT: begin
          if (mul_e_done) begin
            if (run_q) begin
              east_velocity_held <= sat32(vel_e_wide);
              north_velocity_held <= sat32(vel_n_wide);
            end
            state <= ST_PSTART;
          end
        end
        ST_PSTART: state <= ST_PWAIT;
        ST_PWAIT: begin
          if (mul_e_done) begin
            if (pos_en_q) begin
              east_position <= sat_add64(east_position, prod_e[63:0]);
              north_position <= sat_add64(north_position, prod_n[63:0]);
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result_out.valid <= 1'b1;
            result_out.yaw_rate <= yaw_q;
            result_out.vel_east <= east_velocity_held;
            result_out.vel_north <= north_velocity_held;
            result_out.pos_east <= east_position;
            result_out.pos_north <= north_position;
            result_out.heading_out <= heading_q;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // A taken sample closes the input until its result is loaded.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample_in.ready)
    else $error("input accepted while a sample is in work");

  // A new result appears only from the final state of the sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the final state");

  // Both serial multipliers run in lock step.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    mul_e_done == mul_n_done)
    else $error("multipliers out of step");
`endif

endmodule
`default_nettype wire

### src/dri_serial_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add.
`default_nettype none
module dri_serial_mul (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [dri_pkg::MUL_W-1:0] a,
  input  wire logic signed [dri_pkg::MUL_W-1:0] b,
  output logic done,
  output logic signed [dri_pkg::PROD_W-1:0] product
);
  import dri_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic signed [MUL_W+1:0] acc;
  logic signed [MUL_W+1:0] mcand;
  logic [MUL_W-1:0] bsr;
  logic [MUL_W-1:0] lo;
  logic signed [MUL_W+1:0] addend;
  logic signed [MUL_W+1:0] sum;

  // The sign bit of the multiplier carries negative weight.
  always_comb begin
    if (!bsr[0]) begin
      addend = '0;
    end else if (cnt == LAST) begin
      addend = -mcand;
    end else begin
      addend = mcand;
    end
    sum = acc + addend;
  end

  // Accumulate the upper half and shift finished low bits into lo.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        acc <= '0;
        lo <= '0;
        bsr <= b;
        mcand <= {{2{a[MUL_W-1]}}, a};
      end else if (busy) begin
        acc <= sum >>> 1;
        lo <= {sum[0], lo[MUL_W-1:1]};
        bsr <= bsr >> 1;
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = {acc[MUL_W-1:0], lo};

endmodule
`default_nettype wire

### src/dri_sincos.sv
// Heading reduction and iterative CORDIC rotator giving sine and cosine in Q2.30.
`default_nettype none
module dri_sincos #(
  parameter int STEPS = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [31:0] heading,
  output logic done,
  output logic signed [dri_pkg::ANG_W-1:0] sin_q,
  output logic signed [dri_pkg::ANG_W-1:0] cos_q
);
  import dri_pkg::*;

  localparam logic [5:0] LAST = 6'(STEPS - 1);

  typedef enum logic [1:0] {S_IDLE, S_RED, S_FOLD, S_ROT} state_t;

  state_t state;
  logic [2:0] k;
  logic [5:0] cnt;
  logic neg;
  logic signed [ANG_W-1:0] r;
  logic signed [ANG_W-1:0] x;
  logic signed [ANG_W-1:0] y;
  logic signed [ANG_W-1:0] z;
  logic signed [ANG_W-1:0] r1;
  logic signed [ANG_W-1:0] r2;
  logic neg_next;
  logic signed [ANG_W-1:0] step_val;
  logic signed [ANG_W-1:0] dx;
  logic signed [ANG_W-1:0] dy;
  logic signed [ANG_W-1:0] at;

  // Fold the reduced angle into [-pi/2, pi/2].
  always_comb begin
    r1 = (r > PI_VAL) ? r - TWO_PI : r;
    r2 = r1;
    neg_next = 1'b0;
    if (r1 > HALF_PI) begin
      r2 = r1 - PI_VAL;
      neg_next = 1'b1;
    end else if (r1 < -HALF_PI) begin
      r2 = r1 + PI_VAL;
      neg_next = 1'b1;
    end
  end

  assign step_val = reduce_step(k);
  assign dx = y >>> cnt[4:0];
  assign dy = x >>> cnt[4:0];
  assign at = $signed({4'b0000, atan_q30(cnt[4:0])});

  // One reduction step or one rotation per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      k <= '0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            // A negative heading is lifted by 32 turns so that floor modulo stays positive.
            r <= heading[31] ? 34'(heading) + reduce_step(3'd5) : 34'(heading);
            k <= 3'd5;
            state <= S_RED;
          end
        end
        S_RED: begin
          if (r >= step_val) begin
            r <= r - step_val;
          end
          if (k == 3'd0) begin
            state <= S_FOLD;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_FOLD: begin
          z <= r2 <<< 6;
          neg <= neg_next;
          x <= CORDIC_GAIN;
          y <= '0;
          cnt <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          if (!z[ANG_W-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - at;
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + at;
          end
          cnt <= cnt + 1'b1;
          if (cnt == LAST) begin
            state <= S_IDLE;
            done <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign sin_q = neg ? -y : y;
  assign cos_q = neg ? -x : x;

endmodule
`default_nettype wire

### test/tb.sv
// Testbench of the dead reckoning integrator: yaw correction, velocity and position checks.
`timescale 1ns / 1ps
module tb;
  import dri_pkg::*;

  logic clk;
  logic rst;
  dri_in_if sample_if();
  dri_out_if result_if();
  dri_cfg_if cfg_if();

  dead_reckoning_integrator_unit dut (
    .clk(clk),
    .rst(rst),
    .sample_in(sample_if.sink),
    .result_out(result_if.source),
    .cfg_wr(cfg_if.sink)
  );

  typedef struct {
    logic signed [31:0] raw;
    logic signed [31:0] spd;
    logic signed [31:0] hdg;
    logic signed [31:0] mov_off;
    logic signed [31:0] stp_off;
    logic mov_ok;
    logic spd_ok;
    logic hdg_ok;
    logic [31:0] stamp;
  } sample_t;

  typedef struct {
    logic signed [31:0] yaw;
    logic signed [31:0] ve;
    logic signed [31:0] vn;
    logic signed [63:0] pe;
    logic signed [63:0] pn;
    logic signed [31:0] hdg;
  } nav_t;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int STALL_CYCLES = 1500;

  // Predictor state, kept apart from the block.
  logic nav_reverse;
  logic [30:0] nav_threshold;
  logic [1:0] nav_phase;
  logic nav_seen;
  logic [31:0] nav_last_time;
  logic signed [31:0] nav_ve;
  logic signed [31:0] nav_vn;
  logic signed [63:0] nav_pe;
  logic signed [63:0] nav_pn;

  nav_t expected_navs[$];
  int fail_count;
  int result_count;
  longint cycle_count;
  logic long_hold;
  logic [31:0] stamp_now;

  // Arctangent table entries of the rotator, Q2.30.
  function automatic longint atan_entry(input int i);
    longint t[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                      524288, 262144, 131072, 65536, 32768, 16384, 8192,
                      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] add_clamped(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // Sine and cosine in Q2.30 of a Q8.24 heading, rotation-mode CORDIC.
  task automatic heading_trig(input longint hdg, output longint s, output longint c);
    longint r, x, y, z, dx, dy;
    logic flip;
    r = hdg % 105414357;
    flip = 0;
    x = 652032874;
    y = 0;
    if (r < 0) r += 105414357;
    if (r > 52707179) r -= 105414357;
    if (r > 26353589) begin
      r -= 52707179;
      flip = 1;
    end else if (r < -26353589) begin
      r += 52707179;
      flip = 1;
    end
    z = r * 64;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= atan_entry(i);
      end else begin
        x += dx;
        y -= dy;
        z += atan_entry(i);
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  // Advance the predictor by one sample and queue the expected result.
  task automatic predict_nav(input sample_t smp);
    longint rate, s, c, spd, dt;
    nav_t e;
    spd = smp.spd;
    rate = nav_reverse ? -longint'(smp.raw) : longint'(smp.raw);
    if (spd > longint'({1'b0, nav_threshold}) && smp.mov_ok) rate += smp.mov_off;
    else rate += smp.stp_off;
    e.yaw = clamp32(rate);
    if (nav_phase == 0) begin
      if (smp.spd_ok && smp.hdg_ok) nav_phase = 1;
    end else if (nav_phase == 1) begin
      nav_phase = 2;
    end
    if (nav_phase >= 2) begin
      heading_trig(smp.hdg, s, c);
      nav_ve = clamp32((spd * s + (64'sd1 <<< 29)) >>> 30);
      nav_vn = clamp32((spd * c + (64'sd1 <<< 29)) >>> 30);
      if (spd > 0 && nav_seen) begin
        dt = longint'({32'd0, smp.stamp - nav_last_time});
        nav_pe = add_clamped(nav_pe, longint'(nav_ve) * dt);
        nav_pn = add_clamped(nav_pn, longint'(nav_vn) * dt);
      end
    end
    nav_last_time = smp.stamp;
    nav_seen = 1;
    e.ve = nav_ve;
    e.vn = nav_vn;
    e.pe = nav_pe;
    e.pn = nav_pn;
    e.hdg = smp.hdg;
    expected_navs.push_back(e);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: own stall pattern, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 0;
    end else if (long_hold) begin
      result_if.ready <= 0;
    end else begin
      case (cycle_count[9:8])
        2'd0: result_if.ready <= 1;
        2'd1: result_if.ready <= ($urandom_range(0, 3) != 0);
        2'd2: result_if.ready <= ($urandom_range(0, 3) == 0);
        default: result_if.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    nav_t e;
    if (!rst && result_if.valid && result_if.ready) begin
      result_count++;
      if (expected_navs.size() == 0) begin
        $error("Result transaction with no expectation waiting.");
        fail_count++;
      end else begin
        e = expected_navs.pop_front();
        if (result_if.yaw_rate !== e.yaw) begin
          $error("yaw_rate expected %0d actual %0d", e.yaw, result_if.yaw_rate);
          fail_count++;
        end
        if (result_if.vel_east !== e.ve) begin
          $error("vel_east expected %0d actual %0d", e.ve, result_if.vel_east);
          fail_count++;
        end
        if (result_if.vel_north !== e.vn) begin
          $error("vel_north expected %0d actual %0d", e.vn, result_if.vel_north);
          fail_count++;
        end
        if (result_if.pos_east !== e.pe) begin
          $error("pos_east expected %0d actual %0d", e.pe, result_if.pos_east);
          fail_count++;
        end
        if (result_if.pos_north !== e.pn) begin
          $error("pos_north expected %0d actual %0d", e.pn, result_if.pos_north);
          fail_count++;
        end
        if (result_if.heading_out !== e.hdg) begin
          $error("heading_out expected %0d actual %0d", e.hdg, result_if.heading_out);
          fail_count++;
        end
      end
    end
  end

  // Send one sample transaction, after an idle gap of the given length.
  task automatic send_sample(input sample_t smp, input int gap);
    repeat (gap) begin
      sample_if.valid <= 0;
      @(posedge clk);
    end
    sample_if.valid <= 1;
    sample_if.raw_yaw_rate <= smp.raw;
    sample_if.speed <= smp.spd;
    sample_if.heading <= smp.hdg;
    sample_if.moving_offset <= smp.mov_off;
    sample_if.stop_offset <= smp.stp_off;
    sample_if.moving_offset_valid <= smp.mov_ok;
    sample_if.speed_valid <= smp.spd_ok;
    sample_if.heading_valid <= smp.hdg_ok;
    sample_if.sample_time <= smp.stamp;
    do @(posedge clk); while (!sample_if.ready);
    predict_nav(smp);
  endtask

  task automatic stop_sending();
    sample_if.valid <= 0;
    @(posedge clk);
  endtask

  // Write one register while the block is idle.
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] value);
    cfg_if.valid <= 1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 0;
    if (idx == CFG_REVERSE_RATE) nav_reverse = value[0];
    else if (idx == CFG_STOP_THRESHOLD) nav_threshold = value[30:0];
  endtask

  task automatic wait_drained();
    while (expected_navs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random sample: mostly valid, moving, modest speeds; sometimes full range.
  function automatic sample_t random_sample(input bit wild);
    sample_t smp;
    smp.raw = $urandom;
    smp.mov_off = $urandom;
    smp.stp_off = $urandom;
    smp.hdg = $urandom;
    smp.mov_ok = $urandom_range(0, 3) != 0;
    smp.spd_ok = wild ? $urandom_range(0, 1) : ($urandom_range(0, 15) != 0);
    smp.hdg_ok = wild ? $urandom_range(0, 1) : ($urandom_range(0, 15) != 0);
    case ($urandom_range(0, 7))
      0: smp.spd = $urandom;
      1: smp.spd = -$signed(32'($urandom_range(0, 2000000)));
      2: smp.spd = $urandom_range(0, 1400);
      default: smp.spd = $urandom_range(0, 3000000);
    endcase
    if (!wild) begin
      smp.raw = $signed(smp.raw) >>> $urandom_range(0, 12);
      smp.mov_off = $signed(smp.mov_off) >>> $urandom_range(4, 20);
      smp.stp_off = $signed(smp.stp_off) >>> $urandom_range(4, 20);
    end
    return smp;
  endfunction

  // Random burst traffic, stamps advancing by up to 2000 per sample with occasional jumps.
  task automatic test_random_traffic(input int count);
    sample_t smp;
    int burst;
    int gap;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      smp = random_sample($urandom_range(0, 9) == 0);
      stamp_now = ($urandom_range(0, 19) == 0) ? $urandom : stamp_now + $urandom_range(0, 2000);
      smp.stamp = stamp_now;
      gap = 0;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
      end
      burst--;
      send_sample(smp, gap);
    end
    stop_sending();
  endtask

  task automatic test_directed_edges();
    sample_t smp;
    logic signed [31:0] hdgs[8] = '{32'sh7fffffff, 32'sh80000000, 0, 26353589,
                                   -26353589, 52707179, -52707179, 105414357};
    // Not yet valid: velocity and position stay at zero.
    smp = '{32'sh7fffffff, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh7fffffff, 1, 0, 1, 0};
    send_sample(smp, 0);
    smp = '{32'sh80000000, 32'sh80000000, 0, 32'sh80000000, 32'sh80000000, 0, 1, 0, 100};
    send_sample(smp, 0);
    // Both valid: arming, then running on the next sample.
    for (int i = 0; i < 8; i++) begin
      smp = '{32'sh7fffffff, 32'sh7fffffff, hdgs[i], 32'sh7fffffff, 0, 1, 1, 1,
              32'(200 + i * 10)};
      send_sample(smp, i % 2);
    end
    // Time stamp wrap, the largest delta, speed zero and negative.
    smp = '{0, 32'sh7fffffff, 12345678, 0, 0, 1, 1, 1, 32'hffffffff};
    send_sample(smp, 0);
    smp = '{0, 32'sh7fffffff, -12345678, 0, 0, 1, 1, 1, 32'hfffffffe};
    send_sample(smp, 0);
    smp = '{-5, 0, 1, 3, 4, 1, 1, 1, 32'd10};
    send_sample(smp, 0);
    smp = '{7, 32'sh80000000, 1, 3, 4, 1, 1, 1, 32'd20};
    send_sample(smp, 0);
    // Speed just at and above the stop threshold.
    smp = '{100, 655, 0, 1000, -1000, 1, 1, 1, 32'd30};
    send_sample(smp, 0);
    smp = '{100, 656, 0, 1000, -1000, 1, 1, 1, 32'd40};
    send_sample(smp, 0);
    smp = '{100, 656, 0, 1000, -1000, 0, 1, 1, 32'd50};
    send_sample(smp, 0);
    // Repeat large time deltas until position saturates.
    for (int i = 0; i < 4; i++) begin
      smp = '{0, 32'sh7fffffff, 0, 0, 0, 1, 1, 1, 32'(i[0] ? 32'h7fffffff : 32'hffffffff)};
      send_sample(smp, 0);
    end
    stop_sending();
  endtask

  // Long receiver hold-off while the sender keeps offering.
  task automatic test_output_backpressure();
    long_hold = 1;
    fork
      begin
        repeat (STALL_CYCLES) @(posedge clk);
        long_hold = 0;
      end
      test_random_traffic(12);
    join
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    cycle_count = 0;
    long_hold = 0;
    stamp_now = 0;
    nav_reverse = 0;
    nav_threshold = STOP_THRESHOLD_RESET;
    nav_phase = 0;
    nav_seen = 0;
    nav_last_time = 0;
    nav_ve = 0;
    nav_vn = 0;
    nav_pe = 0;
    nav_pn = 0;
    rst = 1;
    sample_if.valid = 0;
    sample_if.raw_yaw_rate = 0;
    sample_if.speed = 0;
    sample_if.heading = 0;
    sample_if.moving_offset = 0;
    sample_if.stop_offset = 0;
    sample_if.moving_offset_valid = 0;
    sample_if.speed_valid = 0;
    sample_if.heading_valid = 0;
    sample_if.sample_time = 0;
    cfg_if.valid = 0;
    cfg_if.index = 0;
    cfg_if.data = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_directed_edges();
    wait_drained();
    write_reg(CFG_REVERSE_RATE, 32'd1);
    write_reg(CFG_STOP_THRESHOLD, 32'd0);
    test_output_backpressure();
    test_random_traffic(400);
    wait_drained();
    write_reg(CFG_STOP_THRESHOLD, 32'hffffffff);
    test_random_traffic(300);
    wait_drained();
    write_reg(CFG_REVERSE_RATE, 32'd0);
    write_reg(CFG_STOP_THRESHOLD, 32'd500000);
    test_random_traffic(720);
    wait_drained();

    $display("Ran %0d results through yaw correction, CORDIC velocity and position",
             result_count);
    $display("integration under three threshold/sign settings and a long output stall.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

### sim.f
src/dri_pkg.sv
src/dri_if.sv
src/dri_serial_mul.sv
src/dri_sincos.sv
src/dead_reckoning_integrator_unit.sv
test/tb.sv
